// ===== rtl/core/neighbor_cooccurrence_counter_assert.svh =====
// Assertion macros for the co-occurrence counter.
// Each use expands to one labeled concurrent assertion clocked on clk and
// disabled while rst_n is low.
`ifndef NEIGHBOR_COOCCURRENCE_COUNTER_ASSERT_SVH
`define NEIGHBOR_COOCCURRENCE_COUNTER_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define NCC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("ncc: invariant violated");

// When the trigger holds, the consequence must hold in the next cycle.
`define NCC_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("ncc: sequence violated");

`endif

// ===== rtl/core/ncc_pkg.sv =====
`timescale 1ns / 1ps
package ncc_pkg;

  localparam int CFG_DATA_W  = 7;
  localparam int CFG_INDEX_W = 2;
  localparam int TILE_W      = 2;
  localparam int OUT_COUNT_W = 16;
  localparam int ROW_LIMIT   = 64;
  localparam int ROW_W       = 7;

  localparam logic [CFG_DATA_W-1:0] ROW_WIDTH_RST = 7'd16;
  localparam logic [CFG_DATA_W-1:0] ROW_COUNT_RST = 7'd16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ROW_WIDTH = 2'd0,
    CFG_ROW_COUNT = 2'd1
  } cfg_reg_t;

endpackage

// ===== rtl/core/neighbor_cooccurrence_counter.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Ports                                        | Transfer
// ---------+-----------+----------------------------------------------+--------------------------
// in       | sink      | in_valid, in_stall, in_tile_id               | in_valid && !in_stall
// out      | source    | out_valid, out_stall, out_origin_id,         | out_valid && !out_stall
//          |           | out_neighbor_id, out_pair_count, out_last_of_run |
// cfg      | sink      | cfg_we, cfg_index, cfg_wdata                 | cfg_we
//
// One pixel is taken per cycle unless in_stall holds; its up to nine counter
// increments land in the count registers at the edge of the transfer.
// The frame's last pixel copies the matrix into a readout bank, which drains one
// entry per cycle while out_stall is low, as the next frame streams in.
// A frame's last pixel stalls only while the previous readout is still draining.
// Reset is synchronous: counters clear, both registers return to 16.
// No clearing pass: the row store is read only at columns the row above wrote.
module neighbor_cooccurrence_counter
  import ncc_pkg::*;
#(
  parameter int NUM_TILES  = 4,
  parameter int MAX_WIDTH  = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // pixel input
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [TILE_W-1:0]      in_tile_id,
  // matrix readout
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [TILE_W-1:0]      out_origin_id,
  output logic [TILE_W-1:0]      out_neighbor_id,
  output logic [OUT_COUNT_W-1:0] out_pair_count,
  output logic                   out_last_of_run,
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int TW  = $clog2(NUM_TILES);
  localparam int OXW = (TW > TILE_W) ? TW : TILE_W;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int LW  = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int OW  = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [TW-1:0]         TILE_LAST = TW'(NUM_TILES - 1);

  // configuration registers
  logic [CFG_DATA_W-1:0] row_width_r;
  logic [CFG_DATA_W-1:0] row_count_r;
  logic                  restart;

  // frame position and neighbor ids
  logic [LW-1:0]    col_r;
  logic [ROW_W-1:0] row_r;
  logic [TW-1:0]    left_r;
  logic [TW-1:0]    up_r;
  logic [TW-1:0]    ul_r;
  logic [TW-1:0]    ur_r;
  logic [TW-1:0]    row0_r;
  logic [TW-1:0]    row1_r;
  logic [TW-1:0]    row_mem [MAX_WIDTH];

  // counts
  logic [COUNT_BITS-1:0] cnt_r  [NUM_TILES][NUM_TILES];
  logic [COUNT_BITS-1:0] sat_nxt [NUM_TILES][NUM_TILES];
  logic [COUNT_BITS-1:0] snap_r [NUM_TILES][NUM_TILES];

  // readout
  logic          rd_active_r;
  logic [TW-1:0] oi_r;
  logic [TW-1:0] ni_r;
  logic          out_valid_r;
  logic [TILE_W-1:0]      out_origin_r;
  logic [TILE_W-1:0]      out_neighbor_r;
  logic [OUT_COUNT_W-1:0] out_count_r;
  logic                   out_last_r;

  logic [LW-1:0]    w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [TW-1:0]    tile;
  logic             col_last;
  logic             row_last;
  logic             frame_last;
  logic             has_left;
  logic             has_up;
  logic             has_ur;
  logic             accept;
  logic             out_load;
  logic [LW:0]      ra_wide;
  logic [AW-1:0]    ra_idx;
  logic [OXW-1:0]   oi_ext;
  logic [OXW-1:0]   ni_ext;
  logic [OW-1:0]    cnt_ext;

  // Clamp the geometry registers to the supported range.
  always_comb begin
    if (row_width_r == '0) begin
      w_eff = LW'(1);
    end else if (LW'(row_width_r) > LW'(MAX_WIDTH)) begin
      w_eff = LW'(MAX_WIDTH);
    end else begin
      w_eff = LW'(row_width_r);
    end
    if (row_count_r == '0) begin
      h_eff = ROW_W'(1);
    end else if (row_count_r > ROW_W'(ROW_LIMIT)) begin
      h_eff = ROW_W'(ROW_LIMIT);
    end else begin
      h_eff = row_count_r;
    end
  end

  // Saturate ids beyond the palette to the last tile.
  always_comb begin
    if (int'(in_tile_id) >= NUM_TILES) begin
      tile = TILE_LAST;
    end else begin
      tile = TW'(in_tile_id);
    end
  end

  assign col_last   = (col_r == w_eff - LW'(1));
  assign row_last   = (row_r == h_eff - ROW_W'(1));
  assign frame_last = col_last && row_last;
  assign has_left   = (col_r != '0);
  assign has_up     = (row_r != '0);
  assign has_ur     = !col_last;

  // Hold the frame's last pixel until the readout bank is free.
  assign in_stall = rd_active_r && frame_last;
  assign accept   = in_valid && !in_stall;
  assign restart  = cfg_we && (cfg_index inside {CFG_ROW_WIDTH, CFG_ROW_COUNT});

  // Increment for each matrix entry: self pair plus both orderings for each
  // neighbor already seen, then saturate.
  always_comb begin
    logic [3:0]            inc;
    logic [COUNT_BITS:0]   sum;
    logic                  ta;
    logic                  tb;
    for (int a = 0; a < NUM_TILES; a++) begin
      for (int b = 0; b < NUM_TILES; b++) begin
        ta  = (tile == TW'(a));
        tb  = (tile == TW'(b));
        inc = 4'(ta && tb);
        if (has_left) begin
          inc = inc + 4'(ta && (left_r == TW'(b))) + 4'(tb && (left_r == TW'(a)));
        end
        if (has_up) begin
          inc = inc + 4'(ta && (up_r == TW'(b))) + 4'(tb && (up_r == TW'(a)));
          if (has_left) begin
            inc = inc + 4'(ta && (ul_r == TW'(b))) + 4'(tb && (ul_r == TW'(a)));
          end
          if (has_ur) begin
            inc = inc + 4'(ta && (ur_r == TW'(b))) + 4'(tb && (ur_r == TW'(a)));
          end
        end
        sum = {1'b0, cnt_r[a][b]} + (COUNT_BITS + 1)'(inc);
        if (sum > {1'b0, CNT_MAX}) begin
          sat_nxt[a][b] = CNT_MAX;
        end else begin
          sat_nxt[a][b] = sum[COUNT_BITS-1:0];
        end
      end
    end
  end

  // Upper-right id for the next pixel: two columns ahead in the row store.
  assign ra_wide = {1'b0, col_r} + (LW + 1)'(2);
  assign ra_idx  = (ra_wide < (LW + 1)'(MAX_WIDTH)) ? ra_wide[AW-1:0] : '0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RST;
      row_count_r <= ROW_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_WIDTH: row_width_r <= cfg_wdata;
        CFG_ROW_COUNT: row_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // frame position and left / upper-left ids
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r  <= '0;
      row_r  <= '0;
      left_r <= '0;
      ul_r   <= '0;
    end else if (accept) begin
      left_r <= tile;
      ul_r   <= up_r;
      if (col_last) begin
        col_r <= '0;
        row_r <= row_last ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + LW'(1);
      end
    end
  end

  // Row store and the upper / upper-right pipeline. Columns 0 and 1 of the
  // row just finished are kept aside, since the wrap needs both at once.
  always_ff @(posedge clk) begin
    if (accept) begin
      row_mem[col_r[AW-1:0]] <= tile;
      if (col_r == '0) begin
        row0_r <= tile;
      end
      if (col_r == LW'(1)) begin
        row1_r <= tile;
      end
      if (col_last) begin
        up_r <= (col_r == '0) ? tile : row0_r;
        ur_r <= (col_r == LW'(1)) ? tile : row1_r;
      end else begin
        up_r <= ur_r;
        ur_r <= row_mem[ra_idx];
      end
    end
  end

  // Live counts; the frame end moves them to the readout bank and clears them.
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      for (int a = 0; a < NUM_TILES; a++) begin
        for (int b = 0; b < NUM_TILES; b++) begin
          cnt_r[a][b] <= '0;
        end
      end
    end else if (accept) begin
      for (int a = 0; a < NUM_TILES; a++) begin
        for (int b = 0; b < NUM_TILES; b++) begin
          cnt_r[a][b] <= frame_last ? '0 : sat_nxt[a][b];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && frame_last) begin
      snap_r <= sat_nxt;
    end
  end

  // Readout: advance the output register whenever it is empty or taken.
  assign out_load = !out_valid_r || !out_stall;
  assign oi_ext   = OXW'(oi_r);
  assign ni_ext   = OXW'(ni_r);
  assign cnt_ext  = OW'(snap_r[oi_r][ni_r]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_active_r <= 1'b0;
      oi_r        <= '0;
      ni_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        if (rd_active_r) begin
          out_valid_r <= 1'b1;
          if (ni_r == TILE_LAST) begin
            ni_r <= '0;
            if (oi_r == TILE_LAST) begin
              oi_r        <= '0;
              rd_active_r <= 1'b0;
            end else begin
              oi_r <= oi_r + TW'(1);
            end
          end else begin
            ni_r <= ni_r + TW'(1);
          end
        end else begin
          out_valid_r <= 1'b0;
        end
      end
      // a frame end only transfers with the bank drained
      if (accept && frame_last) begin
        rd_active_r <= 1'b1;
        oi_r        <= '0;
        ni_r        <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && rd_active_r) begin
      out_origin_r   <= oi_ext[TILE_W-1:0];
      out_neighbor_r <= ni_ext[TILE_W-1:0];
      out_count_r    <= cnt_ext[OUT_COUNT_W-1:0];
      out_last_r     <= (oi_r == TILE_LAST) && (ni_r == TILE_LAST);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_origin_id   = out_origin_r;
  assign out_neighbor_id = out_neighbor_r;
  assign out_pair_count  = out_count_r;
  assign out_last_of_run = out_last_r;

  `include "neighbor_cooccurrence_counter_assert.svh"

  // A readout never gaps before its last entry.
  `NCC_ASSERT_NEXT(a_readout_gapless, out_valid && !out_stall && !out_last_of_run, out_valid)
  // A frame end restarts the readout at the first matrix entry.
  `NCC_ASSERT_NEXT(a_frame_end_readout, accept && frame_last, rd_active_r && (oi_r == '0) && (ni_r == '0))
  // The column position always lies inside the configured row.
  `NCC_ASSERT_ALWAYS(a_col_in_row, col_r < w_eff)

endmodule

// ===== sim/neighbor_cooccurrence_counter_test.sv =====
`timescale 1ns / 1ps
module neighbor_cooccurrence_counter_test;
  import ncc_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int NUM_TILES     = 4;
  localparam int MAX_WIDTH     = 64;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 20;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_ITEMS  = 6;
  localparam time TIMEOUT_NS   = 2_000_000;

  localparam logic [OUT_COUNT_W-1:0] COUNT_MAX = '1;

  // Indexes that map to no register; writes to them must be ignored.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum int {
    PACE_STEADY,
    PACE_SPARSE_SOURCE,
    PACE_SLOW_SINK,
    PACE_LIGHT_JITTER
  } pace_t;

  typedef struct {
    logic [TILE_W-1:0]      origin;
    logic [TILE_W-1:0]      neighbor;
    logic [OUT_COUNT_W-1:0] count;
    logic                   last;
  } matrix_entry_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [TILE_W-1:0]      in_tile_id = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [TILE_W-1:0]      out_origin_id;
  logic [TILE_W-1:0]      out_neighbor_id;
  logic [OUT_COUNT_W-1:0] out_pair_count;
  logic                   out_last_of_run;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Pacing knobs, in percent per cycle.
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  logic readout_hold = 1'b0;

  int mismatch_count = 0;
  int pixels_sent = 0;
  int frame_pixels = 0;
  logic [CFG_DATA_W-1:0] frame_width_raw = ROW_WIDTH_RST;

  // Predicted readout entries, oldest first.
  matrix_entry_t readout_q[$];

  // Predictor copy of the block's registers and frame state.
  logic [CFG_DATA_W-1:0]  model_width = ROW_WIDTH_RST;
  logic [CFG_DATA_W-1:0]  model_rows = ROW_COUNT_RST;
  logic [OUT_COUNT_W-1:0] model_counts [NUM_TILES][NUM_TILES];
  logic [TILE_W-1:0]      model_prev_row [MAX_WIDTH];
  logic [TILE_W-1:0]      model_upper_left = '0;
  logic [TILE_W-1:0]      model_left = '0;
  int                     model_col = 0;
  int                     model_row = 0;

  neighbor_cooccurrence_counter u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_tile_id      (in_tile_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_origin_id   (out_origin_id),
    .out_neighbor_id (out_neighbor_id),
    .out_pair_count  (out_pair_count),
    .out_last_of_run (out_last_of_run),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Register value 0 acts as 1; anything past the limit acts as the limit.
  function automatic int clamp_extent(input logic [CFG_DATA_W-1:0] raw, input int limit);
    if (raw == 0) return 1;
    if (int'(raw) > limit) return limit;
    return int'(raw);
  endfunction

  function automatic void tally(input logic [TILE_W-1:0] a, input logic [TILE_W-1:0] b);
    if (model_counts[a][b] != COUNT_MAX) model_counts[a][b]++;
  endfunction

  // Symmetric neighborhood: count both orderings of the pair.
  function automatic void tally_pair(input logic [TILE_W-1:0] a, input logic [TILE_W-1:0] b);
    tally(a, b);
    tally(b, a);
  endfunction

  // Clear the matrix and go back to the frame start; the row store keeps its ids.
  function automatic void restart_frame();
    foreach (model_counts[i, j]) model_counts[i][j] = '0;
    model_upper_left = '0;
    model_left = '0;
    model_col = 0;
    model_row = 0;
  endfunction

  function automatic void apply_register_write(input logic [CFG_INDEX_W-1:0] index,
                                               input logic [CFG_DATA_W-1:0] data);
    case (index)
      CFG_ROW_WIDTH: begin
        model_width = data;
        restart_frame();
      end
      CFG_ROW_COUNT: begin
        model_rows = data;
        restart_frame();
      end
      default: ;
    endcase
  endfunction

  // Count one pixel; on the frame's last pixel queue the whole matrix.
  function automatic void count_pixel(input logic [TILE_W-1:0] id);
    int w;
    int h;
    int c;
    int r;
    logic [TILE_W-1:0] above;
    matrix_entry_t entry;
    w = clamp_extent(model_width, MAX_WIDTH);
    h = clamp_extent(model_rows, ROW_LIMIT);
    c = (model_col >= w) ? w - 1 : model_col;
    r = (model_row >= h) ? h - 1 : model_row;
    above = '0;

    tally(id, id);
    if (c > 0) tally_pair(id, model_left);
    if (r > 0) begin
      // The row above always wrote these columns within this frame.
      above = model_prev_row[c];
      tally_pair(id, above);
      if (c > 0) tally_pair(id, model_upper_left);
      if (c + 1 < w) tally_pair(id, model_prev_row[c + 1]);
    end

    model_upper_left = above;
    model_prev_row[c] = id;
    model_left = id;

    if (c + 1 < w) begin
      model_col = c + 1;
      model_row = r;
    end else begin
      model_col = 0;
      if (r + 1 < h) begin
        model_row = r + 1;
      end else begin
        for (int i = 0; i < NUM_TILES; i++) begin
          for (int j = 0; j < NUM_TILES; j++) begin
            entry.origin = i[TILE_W-1:0];
            entry.neighbor = j[TILE_W-1:0];
            entry.count = model_counts[i][j];
            entry.last = (i == NUM_TILES - 1) && (j == NUM_TILES - 1);
            readout_q = {readout_q, entry};
          end
        end
        restart_frame();
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s mismatch, got %0d, want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Sample every channel at the edge: check the readout transfer first, then
  // feed register writes and pixel transfers to the predictor.
  always @(posedge clk) begin : scoreboard
    matrix_entry_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (readout_q.size() == 0) begin
          report_mismatch("readout with nothing pending, pair_count", out_pair_count, 0);
        end else begin
          want = readout_q.pop_front();
          if (out_origin_id !== want.origin)
            report_mismatch("origin_id", out_origin_id, want.origin);
          if (out_neighbor_id !== want.neighbor)
            report_mismatch("neighbor_id", out_neighbor_id, want.neighbor);
          if (out_pair_count !== want.count)
            report_mismatch("pair_count", out_pair_count, want.count);
          if (out_last_of_run !== want.last)
            report_mismatch("last_of_run", out_last_of_run, want.last);
        end
      end
      if (cfg_we) apply_register_write(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) count_pixel(in_tile_id);
    end
  end

  // Receiver: stall at random, or hold off completely while readout_hold is set.
  always @(posedge clk) begin
    out_stall <= readout_hold || ($urandom_range(99) < receiver_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic set_pace(input pace_t pace);
    case (pace)
      PACE_STEADY: begin
        sender_idle_pct = 0;
        receiver_stall_pct <= 0;
      end
      PACE_SPARSE_SOURCE: begin
        sender_idle_pct = 86;
        receiver_stall_pct <= 0;
      end
      PACE_SLOW_SINK: begin
        sender_idle_pct = 0;
        receiver_stall_pct <= 86;
      end
      default: begin
        sender_idle_pct = 10;
        receiver_stall_pct <= 10;
      end
    endcase
  endtask

  // Offer one pixel and hold it until the transfer; the predictor picks it up
  // at the same edge.
  task automatic send_pixel(input logic [TILE_W-1:0] id);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_tile_id <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic send_random_pixels(input int count);
    repeat (count) send_pixel(TILE_W'($urandom_range(NUM_TILES - 1)));
  endtask

  // Drop valid and wait until every predicted entry has been read out.
  task automatic wait_for_readout();
    in_valid <= 1'b0;
    @(posedge clk);
    while (readout_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Registers change only with the block idle.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    wait_for_readout();
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure_frame(input logic [CFG_DATA_W-1:0] width,
                                 input logic [CFG_DATA_W-1:0] rows);
    write_register(CFG_ROW_WIDTH, width);
    write_register(CFG_ROW_COUNT, rows);
    frame_width_raw = width;
    frame_pixels = clamp_extent(width, MAX_WIDTH) * clamp_extent(rows, ROW_LIMIT);
  endtask

  task automatic hold_readout(input int cycles);
    readout_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    readout_hold <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Row width keeps its reset value of 16; a single-row frame shows it.
  task automatic test_width_reset_value();
    write_register(CFG_ROW_COUNT, 7'd1);
    for (int i = 0; i < 16; i++) send_pixel((i % 2 == 0) ? 2'd0 : 2'd3);
    wait_for_readout();
  endtask

  // Smallest frames: every id alone, then uniform and mixed tiny rasters.
  task automatic test_tiny_frames();
    configure_frame(7'd1, 7'd1);
    for (int id = 0; id < NUM_TILES; id++) send_pixel(id[TILE_W-1:0]);
    configure_frame(7'd2, 7'd2);
    repeat (4) send_pixel(2'd3);
    configure_frame(7'd3, 7'd2);
    send_random_pixels(6);
    wait_for_readout();
  endtask

  // A register write aborts a partial frame; a write to a spare index does not.
  task automatic test_register_writes();
    configure_frame(7'd3, 7'd2);
    send_random_pixels(4);
    write_register(CFG_ROW_WIDTH, 7'd3);
    send_random_pixels(6);
    send_random_pixels(2);
    write_register(CFG_SPARE_A, 7'h7F);
    write_register(CFG_SPARE_B, 7'h00);
    send_random_pixels(4);
    wait_for_readout();
  endtask

  // Zero and over-range extents: a one-pixel-wide frame at the row limit, then
  // a single row that spans the whole row store.
  task automatic test_extent_limits();
    configure_frame(7'd0, 7'h7F);
    send_random_pixels(frame_pixels);
    configure_frame(7'h7F, 7'd0);
    send_random_pixels(frame_pixels);
    wait_for_readout();
  endtask

  // Mostly small frames, sometimes a zero extent, sometimes a partial frame
  // cut off by a register write.
  task automatic test_random_frames();
    int target;
    int pick;
    target = pixels_sent + RANDOM_ITEMS;
    while (pixels_sent < target) begin
      pick = $urandom_range(7);
      if (pick == 0)
        configure_frame(7'd0, CFG_DATA_W'($urandom_range(1, 3)));
      else if (pick == 1)
        configure_frame(CFG_DATA_W'($urandom_range(1, 3)), 7'd0);
      else
        configure_frame(CFG_DATA_W'($urandom_range(1, 4)),
                        CFG_DATA_W'($urandom_range(1, 3)));
      if ($urandom_range(5) == 0) begin
        send_random_pixels(int'($urandom_range(frame_pixels - 1)));
        write_register(CFG_ROW_WIDTH, frame_width_raw);
      end
      repeat ($urandom_range(1, 2)) send_random_pixels(frame_pixels);
    end
    wait_for_readout();
  endtask

  // Block the readout for a long stretch while single-pixel frames keep coming,
  // so the next frame end has to stall the input; drain, then repeat under light jitter.
  task automatic test_backpressure();
    set_pace(PACE_STEADY);
    configure_frame(7'd1, 7'd1);
    fork
      hold_readout(LONG_HOLD);
    join_none
    send_random_pixels(12);
    wait_for_readout();
    set_pace(PACE_LIGHT_JITTER);
    send_random_pixels(6);
    wait_for_readout();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    pace_t paces[4];
    paces = '{PACE_STEADY, PACE_SPARSE_SOURCE, PACE_SLOW_SINK, PACE_LIGHT_JITTER};
    foreach (model_prev_row[i]) model_prev_row[i] = '0;
    restart_frame();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_pace(PACE_LIGHT_JITTER);
    test_width_reset_value();
    test_tiny_frames();
    test_register_writes();
    test_extent_limits();
    foreach (paces[i]) begin
      set_pace(paces[i]);
      test_random_frames();
    end
    test_backpressure();

    wait_for_readout();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("neighbor_cooccurrence_counter verification clean");
    else
      $display("neighbor_cooccurrence_counter verification failed");
    $finish;
  end

  // Hard stop if a handshake never completes.
  initial begin
    #(TIMEOUT_NS);
    $display("neighbor_cooccurrence_counter verification failed");
    $finish;
  end

endmodule
